@@ hdl/assert_macros.svh @@
// Assertion macros for the checker file of this block.
// Holds only macro definitions; shmc_checker includes it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

`endif

@@ hdl/shmc_pkg.sv @@
// Shared types, constants and helper functions for the stall homing motor command block.
// No dependencies; every module of the block imports this package.
package shmc_pkg;

   localparam int COUNT_WIDTH = 16;
   localparam int TICK_W      = 16;
   localparam int CMP_W       = (COUNT_WIDTH > TICK_W) ? COUNT_WIDTH : TICK_W;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 31;
   localparam int THR_W       = 29;

   typedef enum logic [1:0] {
      MODE_TICK     = 2'd0,
      MODE_POS_GOAL = 2'd1,
      MODE_VEL_GOAL = 2'd2,
      MODE_STOP     = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      PH_SEARCH = 2'd0,
      PH_SETTLE = 2'd1,
      PH_READY  = 2'd2
   } phase_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DIRECTION = 3'd0,
      CSR_KP_GAIN   = 3'd1,
      CSR_KD_GAIN   = 3'd2,
      CSR_GEAR      = 3'd3,
      CSR_INV_GEAR  = 3'd4,
      CSR_SPEED     = 3'd5,
      CSR_JAM       = 3'd6,
      CSR_TIMEOUT   = 3'd7
   } csr_reg_type;

   typedef struct packed {
      logic               restart;
      logic [1:0]         dir;
      logic [15:0]        kp;
      logic [15:0]        kd;
      logic [15:0]        gear;
      logic [15:0]        inv_gear;
      logic [30:0]        speed;
      logic [THR_W-1:0]   thr;
      logic [15:0]        jam;
      logic [15:0]        timeout;
   } cfg_type;

   typedef struct packed {
      mode_type           mode;
      logic signed [39:0] scaled;
      logic signed [31:0] fb_pos;
      logic signed [31:0] fb_vel;
      logic signed [15:0] fb_torque;
   } item_type;

   typedef struct packed {
      logic [15:0]        kp;
      logic [15:0]        kd;
      logic signed [31:0] pos;
      logic signed [31:0] vel;
      logic signed [32:0] diff;
      logic signed [31:0] lv;
      logic signed [15:0] lt;
      phase_type          phase;
   } mid_type;

   function automatic logic signed [31:0] sat_to_32(input logic signed [40:0] v);
      logic fits;
      fits = (v[40:31] == {10{1'b0}}) || (v[40:31] == {10{1'b1}});
      if (fits) begin
         return v[31:0];
      end else if (v[40]) begin
         return 32'sh8000_0000;
      end else begin
         return 32'sh7FFF_FFFF;
      end
   endfunction

endpackage

@@ hdl/shmc_if.sv @@
// Valid/ready channel interfaces for the request and response sides of the block.
// No dependencies; payload widths are fixed by the item formats.
interface shmc_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         mode;
   logic signed [31:0] goal_value;
   logic signed [31:0] fb_pos;
   logic signed [31:0] fb_vel;
   logic signed [15:0] fb_torque;

   modport source (output valid, mode, goal_value, fb_pos, fb_vel, fb_torque, input ready);
   modport sink (input valid, mode, goal_value, fb_pos, fb_vel, fb_torque, output ready);
endinterface

interface shmc_rsp_if;
   logic               valid;
   logic               ready;
   logic [15:0]        cmd_kp;
   logic [15:0]        cmd_kd;
   logic signed [31:0] cmd_pos;
   logic signed [31:0] cmd_vel;
   logic signed [31:0] joint_pos;
   logic signed [31:0] joint_vel;
   logic signed [15:0] joint_torque;
   logic               is_ready;
   logic [1:0]         phase;

   modport source (output valid, cmd_kp, cmd_kd, cmd_pos, cmd_vel, joint_pos, joint_vel,
                   joint_torque, is_ready, phase, input ready);
   modport sink (input valid, cmd_kp, cmd_kd, cmd_pos, cmd_vel, joint_pos, joint_vel,
                 joint_torque, is_ready, phase, output ready);
endinterface

@@ hdl/stall_homing_motor_command.sv @@
// Top level of the stall homing motor command block.
// Depends on shmc_pkg, shmc_if, shmc_cfg, shmc_in, shmc_core and shmc_out.
//
// The block takes one request per clock and returns one response per request, in order.
// A request passes three register stages: the input register (goal times gear ratio), the
// state update (homing phase, counters, zero offset, commands) and the output register
// (feedback times reciprocal gear ratio). The throughput of one item per cycle is set only
// by the response side taking results; while it stalls, up to three items are held.
// Configuration writes are taken at any time but must come with no item in flight;
// a write of the direction restarts homing in the following cycle.
module stall_homing_motor_command (
   input  logic                             clock,
   input  logic                             reset,
   shmc_req_if.sink                         req_ch,
   shmc_rsp_if.source                       rsp_ch,
   input  logic                             csr_wr_en,
   input  logic [shmc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [shmc_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import shmc_pkg::*;

   cfg_type  cfg;
   logic     in_valid, in_take, mid_valid, out_ready;
   item_type in_item;
   mid_type  mid_item;

   shmc_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   shmc_in u_in (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .req      (req_ch),
      .in_valid (in_valid),
      .in_item  (in_item),
      .in_take  (in_take)
   );

   shmc_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (in_valid),
      .in_item   (in_item),
      .in_take   (in_take),
      .mid_valid (mid_valid),
      .mid_item  (mid_item),
      .out_ready (out_ready)
   );

   shmc_out u_out (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .mid_valid (mid_valid),
      .mid_item  (mid_item),
      .out_ready (out_ready),
      .rsp       (rsp_ch)
   );

endmodule

@@ hdl/shmc_cfg.sv @@
// Configuration register file with the stall threshold precomputed on write.
// Depends on shmc_pkg.
module shmc_cfg (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [shmc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [shmc_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output shmc_pkg::cfg_type                cfg
);
   import shmc_pkg::*;

   cfg_type     cfg_ff, cfg_in;
   logic [63:0] thr_prod;

   // Division by five as a multiply by the scaled reciprocal; exact for 32-bit operands.
   assign thr_prod = {33'd0, csr_wdata} * 64'hCCCC_CCCD;

   always_comb begin
      cfg_in         = cfg_ff;
      cfg_in.restart = 1'b0;
      if (csr_wr_en) begin
         case (csr_reg_type'(csr_index))
            CSR_DIRECTION: begin
               // A pattern of minus two is taken as minus one.
               cfg_in.dir     = {csr_wdata[1], csr_wdata[1] | csr_wdata[0]};
               cfg_in.restart = 1'b1;
            end
            CSR_KP_GAIN:  cfg_in.kp       = csr_wdata[15:0];
            CSR_KD_GAIN:  cfg_in.kd       = csr_wdata[15:0];
            CSR_GEAR:     cfg_in.gear     = csr_wdata[15:0];
            CSR_INV_GEAR: cfg_in.inv_gear = csr_wdata[15:0];
            CSR_SPEED: begin
               cfg_in.speed = csr_wdata[30:0];
               cfg_in.thr   = thr_prod[62:34];
            end
            CSR_JAM:      cfg_in.jam      = csr_wdata[15:0];
            CSR_TIMEOUT:  cfg_in.timeout  = csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.restart  <= 1'b0;
         cfg_ff.dir      <= 2'b00;
         cfg_ff.kp       <= 16'd0;
         cfg_ff.kd       <= 16'd0;
         cfg_ff.gear     <= 16'd1620;
         cfg_ff.inv_gear <= 16'd10354;
         cfg_ff.speed    <= 31'd0;
         cfg_ff.thr      <= '0;
         cfg_ff.jam      <= 16'd100;
         cfg_ff.timeout  <= 16'd1000;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ hdl/shmc_in.sv @@
// Input register stage: captures a request transfer and scales the goal by the gear ratio.
// Depends on shmc_pkg and shmc_req_if.
module shmc_in (
   input  logic                 clock,
   input  logic                 reset,
   input  shmc_pkg::cfg_type    cfg,
   shmc_req_if.sink             req,
   output logic                 in_valid,
   output shmc_pkg::item_type   in_item,
   input  logic                 in_take
);
   import shmc_pkg::*;

   logic               in_valid_ff, in_valid_in;
   item_type           item_ff, item_in;
   logic signed [16:0] gear_s;
   logic signed [48:0] goal_prod;
   logic               load;

   assign req.ready = !in_valid_ff || in_take;
   assign load      = req.valid && req.ready;

   assign gear_s    = {1'b0, cfg.gear};
   assign goal_prod = req.goal_value * gear_s;

   always_comb begin
      item_in.mode      = mode_type'(req.mode);
      // Dropping the low eight bits of the product is a floor division by 256.
      item_in.scaled    = goal_prod[47:8];
      item_in.fb_pos    = req.fb_pos;
      item_in.fb_vel    = req.fb_vel;
      item_in.fb_torque = req.fb_torque;
      in_valid_in       = req.ready ? req.valid : in_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= item_in;
      end
   end

   assign in_valid = in_valid_ff;
   assign in_item  = item_ff;

endmodule

@@ hdl/shmc_core.sv @@
// Homing phase machine, tick counters, zero offset and command registers.
// Depends on shmc_pkg; feeds one staged result per item to the output stage.
module shmc_core (
   input  logic                 clock,
   input  logic                 reset,
   input  shmc_pkg::cfg_type    cfg,
   input  logic                 in_valid,
   input  shmc_pkg::item_type   in_item,
   output logic                 in_take,
   output logic                 mid_valid,
   output shmc_pkg::mid_type    mid_item,
   input  logic                 out_ready
);
   import shmc_pkg::*;

   phase_type              phase_ff, phase_in;
   logic [COUNT_WIDTH-1:0] elapsed_ff, elapsed_in;
   logic [COUNT_WIDTH-1:0] stall_ff, stall_in, stall_step;
   logic signed [31:0]     zero_ff, zero_in;
   logic [15:0]            kp_ff, kp_in, kd_ff, kd_in;
   logic signed [31:0]     pos_ff, pos_in, vel_ff, vel_in;
   logic signed [31:0]     lp_ff, lp_in, lv_ff, lv_in;
   logic signed [15:0]     lt_ff, lt_in;
   logic                   mid_valid_ff, mid_valid_in;
   mid_type                mid_ff, mid_in;
   logic                   adv, is_tick, timeout_hit, jam_hit, moving;
   logic [32:0]            vel_mag;
   logic signed [31:0]     search_vel;
   logic signed [40:0]     pos_sum;

   assign in_take = !mid_valid_ff || out_ready;
   assign adv     = in_valid && in_take;
   assign is_tick = (in_item.mode == MODE_TICK);

   assign timeout_hit = CMP_W'(elapsed_ff) >= CMP_W'(cfg.timeout);
   assign vel_mag     = in_item.fb_vel[31] ? 33'd0 - {1'b1, in_item.fb_vel}
                                           : {1'b0, in_item.fb_vel};
   assign moving      = vel_mag > 33'(cfg.thr);
   assign stall_step  = moving ? '0 : ((stall_ff != '1) ? stall_ff + 1'b1 : stall_ff);
   assign jam_hit     = CMP_W'(stall_step) > CMP_W'(cfg.jam);
   assign search_vel  = cfg.dir[1] ? -$signed({1'b0, cfg.speed}) : $signed({1'b0, cfg.speed});
   assign pos_sum     = {in_item.scaled[39], in_item.scaled} + {{9{zero_ff[31]}}, zero_ff};

   // Next homing phase.
   always_comb begin
      phase_in = phase_ff;
      if (cfg.restart) begin
         phase_in = (cfg.dir != 2'b00) ? PH_SEARCH : PH_SETTLE;
      end else if (adv && is_tick) begin
         case (phase_ff)
            PH_SEARCH: begin
               // A timeout ends the search and the settle time in the same tick.
               if (timeout_hit) begin
                  phase_in = PH_READY;
               end else if (jam_hit) begin
                  phase_in = PH_SETTLE;
               end
            end
            PH_SETTLE: begin
               if (timeout_hit) begin
                  phase_in = PH_READY;
               end
            end
            default: ;
         endcase
      end
   end

   // Counters, zero offset, commands and feedback.
   always_comb begin
      elapsed_in = elapsed_ff;
      stall_in   = stall_ff;
      zero_in    = zero_ff;
      kp_in      = kp_ff;
      kd_in      = kd_ff;
      pos_in     = pos_ff;
      vel_in     = vel_ff;
      lp_in      = lp_ff;
      lv_in      = lv_ff;
      lt_in      = lt_ff;
      if (cfg.restart) begin
         elapsed_in = '0;
         stall_in   = '0;
         zero_in    = '0;
         kp_in      = '0;
         kd_in      = '0;
         pos_in     = '0;
         vel_in     = '0;
      end else if (adv) begin
         case (in_item.mode)
            MODE_TICK: begin
               lp_in = in_item.fb_pos;
               lv_in = in_item.fb_vel;
               lt_in = in_item.fb_torque;
               if (phase_ff == PH_SEARCH) begin
                  if (timeout_hit) begin
                     zero_in = '0;
                     kp_in   = '0;
                     kd_in   = cfg.kd;
                     pos_in  = '0;
                     vel_in  = '0;
                  end else begin
                     stall_in = stall_step;
                     kd_in    = cfg.kd;
                     vel_in   = search_vel;
                     if (jam_hit) begin
                        // Stalled long enough: this position becomes the zero.
                        zero_in = in_item.fb_pos;
                        kp_in   = cfg.kp;
                        kd_in   = '0;
                        pos_in  = in_item.fb_pos;
                        vel_in  = '0;
                     end
                  end
               end
               if (elapsed_ff != '1) begin
                  elapsed_in = elapsed_ff + 1'b1;
               end
            end
            MODE_POS_GOAL: begin
               if (phase_ff == PH_READY) begin
                  kp_in  = cfg.kp;
                  kd_in  = '0;
                  pos_in = sat_to_32(pos_sum);
                  vel_in = '0;
               end
            end
            MODE_VEL_GOAL: begin
               if (phase_ff == PH_READY) begin
                  kp_in  = '0;
                  kd_in  = cfg.kd;
                  pos_in = '0;
                  vel_in = sat_to_32({in_item.scaled[39], in_item.scaled});
               end
            end
            MODE_STOP: begin
               kp_in  = '0;
               kd_in  = '0;
               pos_in = '0;
               vel_in = '0;
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      mid_in.kp    = kp_in;
      mid_in.kd    = kd_in;
      mid_in.pos   = pos_in;
      mid_in.vel   = vel_in;
      mid_in.diff  = {lp_in[31], lp_in} - {zero_in[31], zero_in};
      mid_in.lv    = lv_in;
      mid_in.lt    = lt_in;
      mid_in.phase = phase_in;
      mid_valid_in = in_take ? in_valid : mid_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_SETTLE;
         elapsed_ff   <= '0;
         stall_ff     <= '0;
         zero_ff      <= '0;
         kp_ff        <= '0;
         kd_ff        <= '0;
         pos_ff       <= '0;
         vel_ff       <= '0;
         lp_ff        <= '0;
         lv_ff        <= '0;
         lt_ff        <= '0;
         mid_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         elapsed_ff   <= elapsed_in;
         stall_ff     <= stall_in;
         zero_ff      <= zero_in;
         kp_ff        <= kp_in;
         kd_ff        <= kd_in;
         pos_ff       <= pos_in;
         vel_ff       <= vel_in;
         lp_ff        <= lp_in;
         lv_ff        <= lv_in;
         lt_ff        <= lt_in;
         mid_valid_ff <= mid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mid_ff <= mid_in;
      end
   end

   assign mid_valid = mid_valid_ff;
   assign mid_item  = mid_ff;

endmodule

@@ hdl/shmc_out.sv @@
// Output register stage: scales feedback to the joint side and holds the response.
// Depends on shmc_pkg and shmc_rsp_if.
module shmc_out (
   input  logic                 clock,
   input  logic                 reset,
   input  shmc_pkg::cfg_type    cfg,
   input  logic                 mid_valid,
   input  shmc_pkg::mid_type    mid_item,
   output logic                 out_ready,
   shmc_rsp_if.source           rsp
);
   import shmc_pkg::*;

   logic               out_valid_ff, out_valid_in;
   logic [15:0]        kp_ff, kd_ff;
   logic signed [31:0] pos_ff, vel_ff, jpos_ff, jpos_in, jvel_ff, jvel_in;
   logic signed [15:0] jtrq_ff;
   phase_type          phase_ff;
   logic signed [16:0] inv_s;
   logic signed [49:0] pos_prod;
   logic signed [48:0] vel_prod;
   logic               load;

   assign out_ready = !out_valid_ff || rsp.ready;
   assign load      = mid_valid && out_ready;

   assign inv_s    = {1'b0, cfg.inv_gear};
   assign pos_prod = mid_item.diff * inv_s;
   assign vel_prod = mid_item.lv * inv_s;

   always_comb begin
      // Keeping bits from 16 up floors the Q0.16 scaling.
      jpos_in      = sat_to_32({{7{pos_prod[49]}}, pos_prod[49:16]});
      jvel_in      = sat_to_32({{8{vel_prod[48]}}, vel_prod[48:16]});
      out_valid_in = out_ready ? mid_valid : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kp_ff    <= mid_item.kp;
         kd_ff    <= mid_item.kd;
         pos_ff   <= mid_item.pos;
         vel_ff   <= mid_item.vel;
         jpos_ff  <= jpos_in;
         jvel_ff  <= jvel_in;
         jtrq_ff  <= mid_item.lt;
         phase_ff <= mid_item.phase;
      end
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.cmd_kp       = kp_ff;
   assign rsp.cmd_kd       = kd_ff;
   assign rsp.cmd_pos      = pos_ff;
   assign rsp.cmd_vel      = vel_ff;
   assign rsp.joint_pos    = jpos_ff;
   assign rsp.joint_vel    = jvel_ff;
   assign rsp.joint_torque = jtrq_ff;
   assign rsp.is_ready     = (phase_ff == PH_READY);
   assign rsp.phase        = phase_ff;

endmodule

@@ hdl/shmc_checker.sv @@
// Port-level checks for the stall homing motor command block, bound to its top level.
// Depends on shmc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module shmc_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             csr_wr_en,
   input logic [shmc_pkg::CSR_IDX_W-1:0]   csr_index,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic signed [31:0]               rsp_cmd_pos,
   input logic signed [31:0]               rsp_cmd_vel,
   input logic signed [31:0]               rsp_joint_pos,
   input logic                             rsp_is_ready,
   input logic [1:0]                       rsp_phase
);
   import shmc_pkg::*;

   logic seen_ready_ff, seen_ready_in;
   logic rsp_xfer, dir_write;

   assign rsp_xfer  = rsp_valid && rsp_ready;
   assign dir_write = csr_wr_en && (csr_index == CSR_DIRECTION);

   // Set once a ready response has been transferred; a direction write or a reset clears it.
   always_comb begin
      seen_ready_in = seen_ready_ff;
      if (dir_write) begin
         seen_ready_in = 1'b0;
      end else if (rsp_xfer && (rsp_phase == PH_READY)) begin
         seen_ready_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ready_ff <= 1'b0;
      end else begin
         seen_ready_ff <= seen_ready_in;
      end
   end

   `ASSERT_NEXT(a_rsp_valid_holds, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `ASSERT_NEXT(a_rsp_data_holds, clock, reset, rsp_valid && !rsp_ready, $stable({rsp_cmd_pos, rsp_cmd_vel, rsp_joint_pos, rsp_phase}))
   `ASSERT_IMPLY(a_ready_flag, clock, reset, rsp_valid, (rsp_is_ready == (rsp_phase == PH_READY)) && (rsp_phase != 2'd3))
   `ASSERT_IMPLY(a_ready_sticks, clock, reset, rsp_xfer && seen_ready_ff, rsp_phase == PH_READY)

endmodule

bind stall_homing_motor_command shmc_checker u_shmc_checker (
   .clock         (clock),
   .reset         (reset),
   .csr_wr_en     (csr_wr_en),
   .csr_index     (csr_index),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_cmd_pos   (rsp_ch.cmd_pos),
   .rsp_cmd_vel   (rsp_ch.cmd_vel),
   .rsp_joint_pos (rsp_ch.joint_pos),
   .rsp_is_ready  (rsp_ch.is_ready),
   .rsp_phase     (rsp_ch.phase)
);

@@ bench/tb_top.sv @@
// Self-checking bench for stall_homing_motor_command: directed and random request traffic,
// register writes between phases, and a cycle-free predictor that checks every response.
// Depends on shmc_pkg, the shmc_req_if/shmc_rsp_if interfaces and the block's RTL.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import shmc_pkg::*;

   localparam int          IDLE_LIMIT   = 1000;
   localparam int          LATENCY_WAIT = 8;
   localparam logic [15:0] COUNT_MAX    = 16'hFFFF;

   typedef struct {
      mode_type           mode;
      logic signed [31:0] goal, pos, vel;
      logic signed [15:0] trq;
   } motor_item_type;

   typedef struct {
      logic [15:0]        kp, kd;
      logic signed [31:0] pos, vel, jpos, jvel;
      logic signed [15:0] jtrq;
      logic               rdy;
      phase_type          ph;
   } motor_cmd_type;

   typedef struct {
      logic [1:0]  dir;
      logic [15:0] kp, kd, gear, inv, jam, tmo;
      logic [30:0] speed;
   } settings_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   shmc_req_if req_ch();
   shmc_rsp_if rsp_ch();

   stall_homing_motor_command dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // Predictor copy of the configuration and the homing state.
   logic signed [1:0]  m_dir;
   logic [15:0]        m_kp_gain, m_kd_gain, m_gear, m_inv_gear, m_jam, m_timeout;
   logic [30:0]        m_speed;
   phase_type          m_phase;
   logic [15:0]        m_elapsed, m_stall;
   logic signed [31:0] m_zero, m_cmd_pos, m_cmd_vel, m_fb_pos, m_fb_vel;
   logic [15:0]        m_cmd_kp, m_cmd_kd;
   logic signed [15:0] m_fb_trq;

   motor_cmd_type expected_cmds[$];
   int            error_count     = 0;
   int            idle_cycles     = 0;
   int            rsp_hold_cycles = 0;
   int            burst_left      = 0;
   bit            pacing          = 1'b1;

   function automatic logic signed [31:0] clamp32(longint v);
      if (v > longint'(32'sh7FFF_FFFF)) return 32'sh7FFF_FFFF;
      if (v < longint'(32'sh8000_0000)) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   function automatic void clear_commands();
      m_cmd_kp  = '0;
      m_cmd_kd  = '0;
      m_cmd_pos = '0;
      m_cmd_vel = '0;
   endfunction

   function automatic void restart_homing();
      m_phase   = (m_dir != 0) ? PH_SEARCH : PH_SETTLE;
      m_elapsed = '0;
      m_stall   = '0;
      m_zero    = '0;
      clear_commands();
   endfunction

   function automatic void reset_model();
      m_dir      = '0;
      m_kp_gain  = '0;
      m_kd_gain  = '0;
      m_gear     = 16'd1620;
      m_inv_gear = 16'd10354;
      m_speed    = '0;
      m_jam      = 16'd100;
      m_timeout  = 16'd1000;
      m_fb_pos   = '0;
      m_fb_vel   = '0;
      m_fb_trq   = '0;
      restart_homing();
   endfunction

   function automatic void apply_csr_to_model(csr_reg_type idx, logic [CSR_DATA_W-1:0] v);
      case (idx)
         CSR_DIRECTION: begin
            // The pattern for minus two counts as minus one.
            m_dir = (v[1:0] == 2'b10) ? 2'sb11 : $signed(v[1:0]);
            restart_homing();
         end
         CSR_KP_GAIN:  m_kp_gain  = v[15:0];
         CSR_KD_GAIN:  m_kd_gain  = v[15:0];
         CSR_GEAR:     m_gear     = v[15:0];
         CSR_INV_GEAR: m_inv_gear = v[15:0];
         CSR_SPEED:    m_speed    = v[30:0];
         CSR_JAM:      m_jam      = v[15:0];
         CSR_TIMEOUT:  m_timeout  = v[15:0];
         default: ;
      endcase
   endfunction

   function automatic motor_cmd_type predict_command(motor_item_type it);
      motor_cmd_type r;
      longint        scaled;
      longint        mag;
      scaled = (longint'(it.goal) * longint'(m_gear)) >>> 8;
      case (it.mode)
         MODE_TICK: begin
            m_fb_pos = it.pos;
            m_fb_vel = it.vel;
            m_fb_trq = it.trq;
            if (m_phase == PH_SEARCH) begin
               if (m_elapsed >= m_timeout) begin
                  m_zero    = '0;
                  m_cmd_kp  = '0;
                  m_cmd_kd  = m_kd_gain;
                  m_cmd_pos = '0;
                  m_cmd_vel = '0;
                  m_phase   = PH_SETTLE;
               end else begin
                  mag = (it.vel < 0) ? -longint'(it.vel) : longint'(it.vel);
                  if (mag > longint'(m_speed) / 5) begin
                     m_stall = '0;
                  end else if (m_stall != COUNT_MAX) begin
                     m_stall++;
                  end
                  m_cmd_kd  = m_kd_gain;
                  m_cmd_vel = (m_dir < 0) ? -$signed({1'b0, m_speed}) : $signed({1'b0, m_speed});
                  if (m_stall > m_jam) begin
                     // Stalled at the end stop: this position becomes the zero.
                     m_zero    = m_fb_pos;
                     m_cmd_kp  = m_kp_gain;
                     m_cmd_kd  = '0;
                     m_cmd_pos = m_zero;
                     m_cmd_vel = '0;
                     m_phase   = PH_SETTLE;
                  end
               end
            end
            if (m_phase == PH_SETTLE && m_elapsed >= m_timeout) m_phase = PH_READY;
            if (m_elapsed != COUNT_MAX) m_elapsed++;
         end
         MODE_STOP: clear_commands();
         MODE_POS_GOAL: begin
            if (m_phase == PH_READY) begin
               m_cmd_kp  = m_kp_gain;
               m_cmd_kd  = '0;
               m_cmd_pos = clamp32(scaled + longint'(m_zero));
               m_cmd_vel = '0;
            end
         end
         default: begin
            if (m_phase == PH_READY) begin
               m_cmd_kp  = '0;
               m_cmd_kd  = m_kd_gain;
               m_cmd_pos = '0;
               m_cmd_vel = clamp32(scaled);
            end
         end
      endcase
      r.kp   = m_cmd_kp;
      r.kd   = m_cmd_kd;
      r.pos  = m_cmd_pos;
      r.vel  = m_cmd_vel;
      r.jpos = clamp32(((longint'(m_fb_pos) - longint'(m_zero)) * longint'(m_inv_gear)) >>> 16);
      r.jvel = clamp32((longint'(m_fb_vel) * longint'(m_inv_gear)) >>> 16);
      r.jtrq = m_fb_trq;
      r.rdy  = (m_phase == PH_READY);
      r.ph   = m_phase;
      return r;
   endfunction

   function automatic void field_check(string name, logic signed [31:0] e,
                                       logic signed [31:0] a);
      if (a !== e) begin
         $error("%s: expected %0d, got %0d", name, e, a);
         error_count++;
      end
   endfunction

   // Transfers are sampled at the falling edge, where both channels have settled;
   // the transfer itself completes at the next rising edge.
   always @(negedge clock) begin
      motor_item_type it;
      motor_cmd_type  exp_c;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            it.mode = mode_type'(req_ch.mode);
            it.goal = req_ch.goal_value;
            it.pos  = req_ch.fb_pos;
            it.vel  = req_ch.fb_vel;
            it.trq  = req_ch.fb_torque;
            expected_cmds.push_back(predict_command(it));
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_cmds.size() == 0) begin
               $error("response transfer with no request outstanding");
               error_count++;
            end else begin
               exp_c = expected_cmds.pop_front();
               field_check("cmd_kp", 32'(exp_c.kp), 32'(rsp_ch.cmd_kp));
               field_check("cmd_kd", 32'(exp_c.kd), 32'(rsp_ch.cmd_kd));
               field_check("cmd_pos", exp_c.pos, rsp_ch.cmd_pos);
               field_check("cmd_vel", exp_c.vel, rsp_ch.cmd_vel);
               field_check("joint_pos", exp_c.jpos, rsp_ch.joint_pos);
               field_check("joint_vel", exp_c.jvel, rsp_ch.joint_vel);
               field_check("joint_torque", 32'(exp_c.jtrq), 32'(rsp_ch.joint_torque));
               field_check("is_ready", 32'(exp_c.rdy), 32'(rsp_ch.is_ready));
               field_check("phase", 32'(exp_c.ph), 32'(rsp_ch.phase));
            end
         end
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
   end

   initial begin
      while (idle_cycles < IDLE_LIMIT) @(negedge clock);
      $display("tb_top: errors");
      $finish;
   end

   // Response side: random stall pattern, plus a long hold-off when a test asks for one.
   always @(posedge clock) begin
      int stall_mode;
      int stall_left;
      if (rsp_hold_cycles > 0) begin
         rsp_ch.ready <= 1'b0;
         rsp_hold_cycles--;
      end else begin
         if (stall_left <= 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(1, 60);
         end
         stall_left--;
         case (stall_mode)
            0:       rsp_ch.ready <= 1'b1;
            1:       rsp_ch.ready <= 1'($urandom_range(0, 1));
            default: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   task automatic send_item(motor_item_type it);
      req_ch.valid      <= 1'b1;
      req_ch.mode       <= it.mode;
      req_ch.goal_value <= it.goal;
      req_ch.fb_pos     <= it.pos;
      req_ch.fb_vel     <= it.vel;
      req_ch.fb_torque  <= it.trq;
      do @(negedge clock); while (!req_ch.ready);
      @(posedge clock);
   endtask

   task automatic send_paced(motor_item_type it);
      int gap;
      if (pacing && burst_left == 0) begin
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         burst_left = $urandom_range(1, 24);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      if (burst_left > 0) burst_left--;
      send_item(it);
   endtask

   task automatic wait_for_results();
      req_ch.valid <= 1'b0;
      while (expected_cmds.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(csr_reg_type idx, logic [CSR_DATA_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      apply_csr_to_model(idx, value);
   endtask

   task automatic configure(settings_type s);
      wait_for_results();
      write_csr(CSR_KP_GAIN, CSR_DATA_W'(s.kp));
      write_csr(CSR_KD_GAIN, CSR_DATA_W'(s.kd));
      write_csr(CSR_GEAR, CSR_DATA_W'(s.gear));
      write_csr(CSR_INV_GEAR, CSR_DATA_W'(s.inv));
      write_csr(CSR_SPEED, CSR_DATA_W'(s.speed));
      write_csr(CSR_JAM, CSR_DATA_W'(s.jam));
      write_csr(CSR_TIMEOUT, CSR_DATA_W'(s.tmo));
      write_csr(CSR_DIRECTION, CSR_DATA_W'(s.dir));
      csr_wr_en <= 1'b0;
      // The direction write restarts homing in the following cycle.
      repeat (4) @(posedge clock);
   endtask

   function automatic motor_item_type make_item(mode_type m, int goal, int pos, int vel,
                                                int trq);
      motor_item_type it;
      it.mode = m;
      it.goal = goal;
      it.pos  = pos;
      it.vel  = vel;
      it.trq  = 16'(trq);
      return it;
   endfunction

   function automatic logic [31:0] random_word();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) return 32'h7FFF_FFFF;
      if (pick == 1) return 32'h8000_0000;
      if (pick < 6) return int'($urandom_range(0, 2097152)) - 1048576;
      return $urandom;
   endfunction

   function automatic logic [15:0] random_gain();
      int pick;
      pick = $urandom_range(0, 7);
      if (pick == 0) return 16'h0000;
      if (pick == 1) return 16'hFFFF;
      return 16'($urandom);
   endfunction

   function automatic settings_type random_settings();
      settings_type s;
      s.dir   = 2'($urandom_range(0, 3));
      s.kp    = random_gain();
      s.kd    = random_gain();
      s.gear  = random_gain();
      s.inv   = random_gain();
      s.speed = ($urandom_range(0, 3) == 0) ? 31'($urandom) : 31'($urandom_range(0, 1 << 20));
      s.jam   = ($urandom_range(0, 9) == 0) ? COUNT_MAX : 16'($urandom_range(0, 12));
      s.tmo   = ($urandom_range(0, 14) == 0) ? COUNT_MAX : 16'($urandom_range(0, 60));
      return s;
   endfunction

   // Mostly ticks until homing is done, then mostly goals; tick velocities cluster
   // around the stall threshold so that stalls are detected.
   function automatic motor_item_type random_item();
      motor_item_type it;
      int             pick;
      longint         thr;
      logic [31:0]    mag;
      pick = $urandom_range(0, 99);
      if (m_phase != PH_READY) begin
         if (pick < 85)      it.mode = MODE_TICK;
         else if (pick < 91) it.mode = MODE_POS_GOAL;
         else if (pick < 97) it.mode = MODE_VEL_GOAL;
         else                it.mode = MODE_STOP;
      end else begin
         if (pick < 40)      it.mode = MODE_TICK;
         else if (pick < 68) it.mode = MODE_POS_GOAL;
         else if (pick < 95) it.mode = MODE_VEL_GOAL;
         else                it.mode = MODE_STOP;
      end
      it.goal = random_word();
      it.pos  = random_word();
      thr     = longint'(m_speed) / 5;
      pick    = $urandom_range(0, 99);
      if (pick < 60)      mag = $urandom_range(0, thr[31:0]);
      else if (pick < 75) mag = thr[31:0] + 32'd1;
      else                mag = $urandom;
      it.vel = $urandom_range(0, 1) ? -$signed(mag) : $signed(mag);
      it.trq = 16'($urandom);
      return it;
   endfunction

   task automatic test_reset_state();
      // Default registers: no search, goals ignored until the long timeout.
      send_paced(make_item(MODE_POS_GOAL, 12345, 0, 0, 0));
      send_paced(make_item(MODE_VEL_GOAL, -12345, 0, 0, 0));
      send_paced(make_item(MODE_TICK, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_7FFF));
      send_paced(make_item(MODE_TICK, 0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_8000));
      send_paced(make_item(MODE_STOP, 32'h7FFF_FFFF, 0, 0, 0));
      send_paced(make_item(MODE_TICK, 0, 0, 0, 0));
   endtask

   task automatic test_stall_homing();
      settings_type s;
      int           vel_list[6] = '{1001, -1001, 1000, -1000, 0, 0};
      s = '{dir: 2'b01, kp: 16'h1234, kd: 16'hFFFF, gear: 16'h0100, inv: 16'hFFFF,
            jam: 16'd2, tmo: 16'd12, speed: 31'd5000};
      configure(s);
      foreach (vel_list[i]) send_paced(make_item(MODE_TICK, 0, 70000 + 3 * i, vel_list[i], i));
      repeat (8) send_paced(make_item(MODE_TICK, 0, random_word(), 0, $urandom));
      send_paced(make_item(MODE_POS_GOAL, 32'h7FFF_FFFF, 0, 0, 0));
      send_paced(make_item(MODE_POS_GOAL, 32'h8000_0000, 0, 0, 0));
      send_paced(make_item(MODE_VEL_GOAL, 32'h7FFF_FFFF, 0, 0, 0));
      send_paced(make_item(MODE_VEL_GOAL, 32'h8000_0000, 0, 0, 0));
      send_paced(make_item(MODE_STOP, 0, 0, 0, 0));
   endtask

   task automatic test_search_timeout();
      settings_type s;
      // Direction pattern for minus two, and a stall limit that can never be passed.
      s = '{dir: 2'b10, kp: 16'hFFFF, kd: 16'h0000, gear: 16'hFFFF, inv: 16'h0000,
            jam: COUNT_MAX, tmo: 16'd4, speed: 31'h7FFF_FFFF};
      configure(s);
      repeat (7) send_paced(make_item(MODE_TICK, 0, random_word(), random_word(), $urandom));
      send_paced(make_item(MODE_POS_GOAL, 32'h7FFF_FFFF, 0, 0, 0));
      send_paced(make_item(MODE_POS_GOAL, 32'h8000_0000, 0, 0, 0));
      send_paced(make_item(MODE_VEL_GOAL, -1, 0, 0, 0));
      send_paced(make_item(MODE_VEL_GOAL, 1, 0, 0, 0));
      send_paced(make_item(MODE_STOP, 0, 0, 0, 0));
   endtask

   task automatic test_no_search();
      settings_type s;
      s = '{dir: 2'b00, kp: 16'h0000, kd: 16'h8000, gear: 16'h0000, inv: 16'h8000,
            jam: 16'd0, tmo: 16'd0, speed: 31'd0};
      configure(s);
      send_paced(make_item(MODE_TICK, 0, -5, -7, -1));
      send_paced(make_item(MODE_POS_GOAL, 32'h7FFF_FFFF, 0, 0, 0));
      send_paced(make_item(MODE_VEL_GOAL, 32'h8000_0000, 0, 0, 0));
      send_paced(make_item(MODE_TICK, 0, 32'h8000_0000, 32'h8000_0000, 32'h0000_8000));
      send_paced(make_item(MODE_STOP, 0, 0, 0, 0));
   endtask

   task automatic test_counter_limits();
      settings_type s;
      s = '{dir: 2'b01, kp: 16'h00FF, kd: 16'hFF00, gear: 16'h0001, inv: 16'h0001,
            jam: COUNT_MAX, tmo: COUNT_MAX, speed: 31'd0};
      configure(s);
      repeat (10) send_paced(make_item(MODE_TICK, 0, random_word(), 0, $urandom));
      send_paced(make_item(MODE_POS_GOAL, 1000, 0, 0, 0));
      send_paced(make_item(MODE_VEL_GOAL, 1000, 0, 0, 0));
   endtask

   task automatic test_backpressure();
      settings_type s;
      s     = random_settings();
      s.tmo = 16'd10;
      configure(s);
      pacing          = 1'b0;
      rsp_hold_cycles = 300;
      repeat (40) send_paced(random_item());
      // Sender waits until every response is back before going on.
      wait_for_results();
      pacing = 1'b1;
      repeat (40) send_paced(random_item());
   endtask

   task automatic test_random_phases();
      int n;
      int pause_at;
      repeat (9) begin
         configure(random_settings());
         pacing   = ($urandom_range(0, 3) != 0);
         n        = $urandom_range(80, 130);
         pause_at = ($urandom_range(0, 2) == 0) ? $urandom_range(1, n - 1) : -1;
         for (int i = 0; i < n; i++) begin
            if (i == pause_at) wait_for_results();
            send_paced(random_item());
         end
      end
      pacing = 1'b1;
   endtask

   initial begin
      reset             <= 1'b1;
      csr_wr_en         <= 1'b0;
      csr_index         <= CSR_DIRECTION;
      csr_wdata         <= '0;
      req_ch.valid      <= 1'b0;
      req_ch.mode       <= MODE_TICK;
      req_ch.goal_value <= '0;
      req_ch.fb_pos     <= '0;
      req_ch.fb_vel     <= '0;
      req_ch.fb_torque  <= '0;
      reset_model();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_state();
      test_stall_homing();
      test_search_timeout();
      test_no_search();
      test_counter_limits();
      test_backpressure();
      test_random_phases();

      wait_for_results();
      repeat (LATENCY_WAIT) @(posedge clock);
      if (expected_cmds.size() != 0) begin
         $error("%0d responses never arrived", expected_cmds.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule
